// ===== rtl/uri_percent_utf8_unescaper_assert.svh =====
// ---------------------------------------------------------------------------
// URI unescaper assertion macros
// Shared concurrent assertion forms for the unescaper checker.
// ---------------------------------------------------------------------------
`ifndef URI_PERCENT_UTF8_UNESCAPER_ASSERT_SVH
`define URI_PERCENT_UTF8_UNESCAPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UPUE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upue assertion failed");

// Next-cycle implication, disabled while reset is high.
`define UPUE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upue assertion failed");

// Next-cycle implication that is also checked across reset.
`define UPUE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("upue assertion failed");

`endif

// ===== rtl/upue_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URI unescaper package
// Shared widths, state types and result type of the unescaper.
// ---------------------------------------------------------------------------
package upue_pkg;

  localparam int CHAR_W          = 8;
  localparam int LEN_W           = 11;
  localparam int M_DATA_W        = 24;
  localparam int DEFAULT_MAX_LEN = 1024;

  typedef enum logic [1:0] {
    ESC_IDLE   = 2'd0,
    ESC_FIRST  = 2'd1,
    ESC_SECOND = 2'd2
  } esc_phase_t;

  typedef struct packed {
    esc_phase_t  phase;
    logic [3:0]  high_nibble;
    logic        high_is_hex;
    logic [7:0]  acc;
    logic [2:0]  pending;
    logic        finished;
  } state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              is_end;
    logic [LEN_W-1:0]  out_length;
  } result_t;

endpackage

// ===== rtl/upue_in_reg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URI unescaper input register
// Holds one incoming character until the decode stage takes it.
// ---------------------------------------------------------------------------
module upue_in_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [upue_pkg::CHAR_W-1:0] s_tdata,
  input  logic                       s_tuser,
  input  logic                       take,
  output logic                       valid,
  output logic [upue_pkg::CHAR_W-1:0] char_q,
  output logic                       start_q
);
  import upue_pkg::*;

  // A new transaction may enter when the register is empty or the held one leaves this cycle.
  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      char_q  <= s_tdata;
      start_q <= s_tuser;
    end
  end

endmodule

// ===== rtl/upue_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URI unescaper decode step
// Next state, byte count and optional result for one character.
// ---------------------------------------------------------------------------
module upue_step #(
  parameter int MAX_LEN = upue_pkg::DEFAULT_MAX_LEN,
  parameter int CNT_W   = $clog2(MAX_LEN + 1)
) (
  input  logic [upue_pkg::CHAR_W-1:0] char_in,
  input  logic                        start_req,
  input  upue_pkg::state_t            st,
  input  logic [CNT_W-1:0]            cnt,
  output upue_pkg::state_t            st_next,
  output logic [CNT_W-1:0]            cnt_next,
  output logic                        res_valid,
  output upue_pkg::result_t           res
);
  import upue_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  state_t           base;
  logic [CNT_W-1:0] base_cnt;
  logic [4:0]       hv;
  logic             take;
  logic [7:0]       v;
  logic [7:0]       val;
  logic [7:0]       acc_new;
  logic             emit;
  logic [7:0]       emit_byte;

  always_comb begin
    base     = start_req ? '0 : st;
    base_cnt = start_req ? '0 : cnt;
    hv       = hex_val(char_in);
    st_next  = base;
    cnt_next = base_cnt;
    take     = 1'b0;
    v        = '0;
    val      = '0;
    acc_new  = '0;
    emit     = 1'b0;
    emit_byte = '0;
    res_valid = 1'b0;
    res       = '0;

    if (base.finished) begin
      // After the end item everything is dropped until a new start.
      res_valid = 1'b0;
    end else if (char_in == CH_NUL || char_in == CH_SPACE) begin
      st_next.finished = 1'b1;
      st_next.phase    = ESC_IDLE;
      res_valid        = 1'b1;
      res.is_end       = 1'b1;
      res.out_length   = LEN_W'(base_cnt);
    end else begin
      case (base.phase)
        ESC_FIRST: begin
          st_next.high_is_hex = hv[4];
          st_next.high_nibble = hv[4] ? hv[3:0] : 4'd0;
          st_next.phase       = ESC_SECOND;
        end
        ESC_SECOND: begin
          st_next.phase = ESC_IDLE;
          if (base.high_is_hex) begin
            take = 1'b1;
            v    = hv[4] ? {base.high_nibble, hv[3:0]} : {4'd0, base.high_nibble};
          end
        end
        default: begin
          st_next.phase = ESC_IDLE;
          if (char_in == CH_PCT) begin
            st_next.phase = ESC_FIRST;
          end else begin
            take = 1'b1;
            v    = (char_in >= 8'h41 && char_in <= 8'h5A) ? (char_in | 8'h20) : char_in;
          end
        end
      endcase

      if (take) begin
        val = (v == CH_BSL) ? CH_SLASH : v;
        if (!val[7]) begin
          st_next.pending = 3'd0;
          emit      = 1'b1;
          emit_byte = val;
        end else if (val[7:6] == 2'b10) begin
          // A continuation byte with no open sequence is dropped.
          if (base.pending != 3'd0) begin
            acc_new         = {base.acc[1:0], val[5:0]};
            st_next.acc     = acc_new;
            st_next.pending = base.pending - 3'd1;
            if (base.pending == 3'd1) begin
              emit      = 1'b1;
              emit_byte = acc_new;
            end
          end
        end else if (val[7:5] == 3'b110) begin
          st_next.acc = val & 8'h1F;  st_next.pending = 3'd1;
        end else if (val[7:4] == 4'b1110) begin
          st_next.acc = val & 8'h0F;  st_next.pending = 3'd2;
        end else if (val[7:3] == 5'b11110) begin
          st_next.acc = val & 8'h07;  st_next.pending = 3'd3;
        end else if (val[7:2] == 6'b111110) begin
          st_next.acc = val & 8'h03;  st_next.pending = 3'd4;
        end else begin
          st_next.acc = val & 8'h01;  st_next.pending = 3'd5;
        end
      end

      if (emit) begin
        // Bytes keep flowing past the limit; only the count stops.
        cnt_next       = (base_cnt < CNT_MAX) ? base_cnt + CNT_W'(1) : base_cnt;
        res_valid      = 1'b1;
        res.out_char   = emit_byte;
        res.is_end     = 1'b0;
        res.out_length = LEN_W'(cnt_next);
      end
    end
  end

endmodule

// ===== rtl/uri_percent_utf8_unescaper.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URI percent and UTF-8 unescaper
// Decodes a URI one character per transaction into decoded bytes and an
// end transaction carrying the saturated byte count.
// ---------------------------------------------------------------------------
//  channel | direction | tdata                             | tuser
//  s_*     | in        | [7:0] char_in                     | start_req
//  m_*     | out       | [7:0] out_char, [18:8] out_length | is_end
//
// One character per cycle is sustained while m_tready does not stall; a
// character passes from the input register through the single decode step
// into the output register. Characters that yield no byte leave no transaction.
// Reset clears all decode state and the valid flags of both registers.
// A stall on m_tready holds the output register and then the input register;
// the input keeps accepting while only the output register is full.
// ---------------------------------------------------------------------------
module uri_percent_utf8_unescaper #(
  parameter int MAX_LEN = upue_pkg::DEFAULT_MAX_LEN
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [upue_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] char_in
  input  logic                          s_tuser,   // [0] start_req
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [upue_pkg::M_DATA_W-1:0] m_tdata,   // [7:0] out_char, [18:8] out_length
  output logic                          m_tuser    // [0] is_end
);
  import upue_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_start;
  logic              fire;

  state_t            st;
  state_t            st_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              res_valid;
  result_t           res;

  assign fire = in_valid && (!m_tvalid || m_tready);

  upue_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .take     (fire),
    .valid    (in_valid),
    .char_q   (in_char),
    .start_q  (in_start)
  );

  upue_step #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W)
  ) u_step (
    .char_in   (in_char),
    .start_req (in_start),
    .st        (st),
    .cnt       (cnt),
    .st_next   (st_next),
    .cnt_next  (cnt_next),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '0;
      cnt <= '0;
    end else if (fire) begin
      st  <= st_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      m_tdata <= {(M_DATA_W - CHAR_W - LEN_W)'(0), res.out_length, res.out_char};
      m_tuser <= res.is_end;
    end
  end

endmodule

// ===== rtl/upue_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URI unescaper port checker
// Watches the top-level ports and is attached to every instance by bind.
// ---------------------------------------------------------------------------
`include "uri_percent_utf8_unescaper_assert.svh"

module upue_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [upue_pkg::M_DATA_W-1:0] m_tdata,
  input logic                          m_tuser
);
  import upue_pkg::*;

  // No transaction can appear in the cycle right after reset.
  `UPUE_ASSERT_NEXT_ALWAYS(a_idle_after_rst, clk, rst, !m_tvalid)

  // The end transaction carries a zero byte.
  `UPUE_ASSERT_NOW(a_end_zero, clk, rst, m_tvalid && m_tuser, m_tdata[CHAR_W-1:0] == '0)

  // A ready input with nothing offered is left empty and stays ready.
  `UPUE_ASSERT_NEXT(a_in_free, clk, rst, !s_tvalid && s_tready, s_tready)

  `UPUE_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind uri_percent_utf8_unescaper upue_checker u_upue_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URI unescaper testbench
// Feeds raw URI characters through the slave stream, predicts every decoded
// byte and end transaction in a local model of the decoder, and compares the
// master stream against it field by field under random bursts and stalls.
// ---------------------------------------------------------------------------
module testbench;

  import upue_pkg::*;

  localparam int MAX_LEN = DEFAULT_MAX_LEN;
  localparam int RANDOM_ITEMS = 2000;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef struct packed {
    logic [7:0] ch;
    logic       start;
  } uri_char_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [CHAR_W-1:0]   s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;

  uri_percent_utf8_unescaper #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),     // [7:0] char_in
    .s_tuser(s_tuser),     // [0] start_req
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),     // [7:0] out_char, [18:8] out_length
    .m_tuser(m_tuser)      // [0] is_end
  );

  always #4 clk = ~clk;

  uri_char_t raw_chars[$];
  result_t   pending_decoded[$];
  int        mismatches = 0;
  int        chars_accepted = 0;
  int        chars_pushed = 0;
  bit        in_taken = 1'b0;
  bit        start_next = 1'b0;

  // Decoder model state.
  state_t      dec_st = '0;
  logic [10:0] dec_count = '0;

  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  function automatic bit emit_decoded(input logic [7:0] b, output result_t res);
    if (dec_count < MAX_LEN) dec_count = dec_count + 11'd1;
    res.out_char = b;
    res.is_end = 1'b0;
    res.out_length = dec_count;
    return 1'b1;
  endfunction

  // One decoded byte value: ASCII, UTF-8 continuation or UTF-8 lead.
  function automatic bit take_decoded(input logic [7:0] v_in, output result_t res);
    logic [7:0] v;
    v = v_in;
    res = '0;
    if (v == CH_BACKSLASH) v = CH_SLASH;
    if (!v[7]) begin
      dec_st.pending = 3'd0;
      return emit_decoded(v, res);
    end
    if (v[7:6] == 2'b10) begin
      if (dec_st.pending == 3'd0) return 1'b0;
      dec_st.acc = {dec_st.acc[1:0], v[5:0]};
      dec_st.pending = dec_st.pending - 3'd1;
      if (dec_st.pending == 3'd0) return emit_decoded(dec_st.acc, res);
      return 1'b0;
    end
    if (v[7:5] == 3'b110) begin
      dec_st.acc = {3'b000, v[4:0]};
      dec_st.pending = 3'd1;
    end else if (v[7:4] == 4'b1110) begin
      dec_st.acc = {4'b0000, v[3:0]};
      dec_st.pending = 3'd2;
    end else if (v[7:3] == 5'b11110) begin
      dec_st.acc = {5'b00000, v[2:0]};
      dec_st.pending = 3'd3;
    end else if (v[7:2] == 6'b111110) begin
      dec_st.acc = {6'b000000, v[1:0]};
      dec_st.pending = 3'd4;
    end else begin
      dec_st.acc = {7'b0000000, v[0]};
      dec_st.pending = 3'd5;
    end
    return 1'b0;
  endfunction

  function automatic bit unescape_char(input logic [7:0] c_in, input logic start,
                                       output result_t res);
    logic [7:0] c;
    int         h;
    c = c_in;
    res = '0;
    if (start) begin
      dec_st = '0;
      dec_count = '0;
    end
    if (dec_st.finished) return 1'b0;
    if (c == CH_NUL || c == CH_SPACE) begin
      dec_st.finished = 1'b1;
      dec_st.phase = ESC_IDLE;
      res.out_char = 8'h00;
      res.is_end = 1'b1;
      res.out_length = dec_count;
      return 1'b1;
    end
    case (dec_st.phase)
      ESC_FIRST: begin
        h = hex_digit_value(c);
        dec_st.high_is_hex = (h >= 0);
        dec_st.high_nibble = (h >= 0) ? h[3:0] : 4'h0;
        dec_st.phase = ESC_SECOND;
        return 1'b0;
      end
      ESC_SECOND: begin
        dec_st.phase = ESC_IDLE;
        if (!dec_st.high_is_hex) return 1'b0;
        h = hex_digit_value(c);
        if (h >= 0) return take_decoded({dec_st.high_nibble, h[3:0]}, res);
        return take_decoded({4'h0, dec_st.high_nibble}, res);
      end
      default: begin
        dec_st.phase = ESC_IDLE;
        if (c == CH_PERCENT) begin
          dec_st.phase = ESC_FIRST;
          return 1'b0;
        end
        if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
        return take_decoded(c, res);
      end
    endcase
  endfunction

  // ---------------- stimulus helpers ----------------

  task automatic push_char(input logic [7:0] c);
    uri_char_t item;
    item.ch = c;
    item.start = start_next;
    start_next = 1'b0;
    raw_chars.push_back(item);
    chars_pushed++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    if ($urandom_range(0, 1) == 0) return 8'h41 + n - 4'd10;
    return 8'h61 + n - 4'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (hex_digit_value(c) >= 0 || c == CH_SPACE);
    return c;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(0, 15) == 0) c = ($urandom_range(0, 1) == 0) ? 8'h7F :
                                         8'($urandom_range(1, 31));
    else c = 8'($urandom_range(8'h21, 8'h7E));
    if (c == CH_PERCENT) c = 8'h41;
    return c;
  endfunction

  function automatic logic [7:0] terminator();
    return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_NUL;
  endfunction

  task automatic push_escape(input logic [7:0] b);
    push_char(CH_PERCENT);
    push_char(hex_char(b[7:4]));
    push_char(hex_char(b[3:0]));
  endtask

  task automatic push_byte(input logic [7:0] b, input bit escaped);
    if (escaped) push_escape(b);
    else push_char(b);
  endtask

  // A UTF-8 sequence, sometimes cut short; raw or percent encoded.
  task automatic push_utf8(input bit escaped);
    int         n;
    int         sent;
    logic [7:0] lead;
    n = $urandom_range(1, 5);
    case (n)
      1: lead = 8'hC0 | 8'($urandom_range(0, 31));
      2: lead = 8'hE0 | 8'($urandom_range(0, 15));
      3: lead = 8'hF0 | 8'($urandom_range(0, 7));
      4: lead = 8'hF8 | 8'($urandom_range(0, 3));
      default: lead = 8'hFC | 8'($urandom_range(0, 3));
    endcase
    sent = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n;
    push_byte(lead, escaped);
    for (int k = 0; k < sent; k++) push_byte(8'h80 | 8'($urandom_range(0, 63)), escaped);
  endtask

  task automatic push_broken_escape();
    push_char(CH_PERCENT);
    case ($urandom_range(0, 5))
      0, 1: begin
        push_char(non_hex_char());
        push_char(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : plain_char());
      end
      2, 3: begin
        push_char(hex_char(4'($urandom_range(0, 15))));
        push_char(non_hex_char());
      end
      4: begin
        push_char(hex_char(4'($urandom_range(0, 15))));
        push_char(terminator());
      end
      default: push_char(terminator());
    endcase
  endtask

  task automatic push_random_uri();
    int tokens;
    tokens = $urandom_range(1, 20);
    start_next = 1'b1;
    for (int t = 0; t < tokens; t++) begin
      if ($urandom_range(0, 49) == 0) start_next = 1'b1;
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4, 5: push_char(plain_char());
        6, 7, 8: push_escape(8'($urandom_range(0, 255)));
        9, 10: push_utf8(1'b0);
        11: push_utf8(1'b1);
        12: push_broken_escape();
        13: push_char(8'($urandom_range(8'h80, 8'hFF)));
        14: push_char(8'($urandom_range(0, 255)));
        default: push_char(($urandom_range(0, 1) == 0) ? CH_BACKSLASH :
                           8'($urandom_range(8'h41, 8'h5A)));
      endcase
    end
    if ($urandom_range(0, 7) != 0) push_char(terminator());
    // Characters after the end are dropped by the block.
    for (int k = $urandom_range(0, 2); k > 0; k--) push_char(8'($urandom_range(0, 255)));
  endtask

  // Long enough that the byte count saturates.
  task automatic push_long_uri();
    start_next = 1'b1;
    for (int k = 0; k < MAX_LEN + 20; k++) push_char(plain_char());
    push_char(CH_SPACE);
  endtask

  task automatic push_directed();
    start_next = 1'b1;
    push_char(8'h41);          // upper case is folded
    push_char(8'h5A);
    push_char(CH_BACKSLASH);   // plain backslash
    push_char(CH_PERCENT);     // decoded 'A' is kept as is
    push_char(8'h34);
    push_char(8'h31);
    push_char(CH_PERCENT);     // decoded backslash
    push_char(8'h35);
    push_char(8'h63);
    push_char(CH_PERCENT);     // non-hex first digit drops the escape
    push_char(8'h67);
    push_char(8'h31);
    push_char(CH_PERCENT);     // non-hex second digit keeps the first alone
    push_char(8'h46);
    push_char(8'h7A);
    push_char(8'hC3);          // two-byte sequence
    push_char(8'hA9);
    push_char(8'h80);          // stray continuation
    push_char(8'hE2);          // cancelled by ASCII
    push_char(8'h61);
    push_char(8'hFF);          // lead expecting five continuations
    push_char(8'h7F);
    push_char(CH_PERCENT);     // end inside an escape
    push_char(CH_SPACE);
    push_char(8'h78);          // ignored while finished
    start_next = 1'b1;
    push_char(CH_NUL);         // empty URI
  endtask

  // ---------------- driver ----------------

  int gap_left = 0;
  int burst_left = 0;
  bit offering = 1'b0;
  logic hold_active = 1'b0;

  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        in_taken = 1'b0;
        raw_chars.delete(0);
        offering = 1'b0;
      end
      if (!offering && raw_chars.size() > 0) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        // Keep pushing while the receiver holds off so the block backs up.
        if (hold_active) gap_left = 0;
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          offering = 1'b1;
          burst_left--;
        end
      end
      s_tvalid <= offering;
      if (offering) begin
        s_tdata <= raw_chars[0].ch;
        s_tuser <= raw_chars[0].start;
      end else begin
        s_tdata <= 8'($urandom);
        s_tuser <= 1'($urandom);
      end
    end
  end

  // ---------------- receiver ----------------

  int rx_cycle = 0;
  int rx_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit rx_ready;

  always @(negedge clk) begin
    if (!rst) begin
      rx_cycle++;
      if (!hold_done && chars_accepted >= 1000) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (rx_mode)
          0: rx_ready = 1'b1;
          1: rx_ready = ($urandom_range(0, 3) != 0);
          2: rx_ready = ($urandom_range(0, 3) == 0);
          default: rx_ready = (rx_cycle % 3 == 0);
        endcase
      end
      m_tready <= rx_ready;
      hold_active <= (hold_left > 0);
    end
  end

  // ---------------- monitor and checker ----------------

  result_t predicted;
  result_t wanted;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (unescape_char(s_tdata, s_tuser, predicted)) pending_decoded.push_back(predicted);
        in_taken = 1'b1;
        chars_accepted++;
      end
      if (m_tvalid && m_tready) begin
        if (pending_decoded.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output transaction: char %02h end %0d len %0d",
                     m_tdata[7:0], m_tuser, m_tdata[18:8]);
        end else begin
          wanted = pending_decoded.pop_front();
          if (m_tdata[7:0] !== wanted.out_char || m_tuser !== wanted.is_end ||
              m_tdata[18:8] !== wanted.out_length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected char %02h end %0d len %0d, got char %02h end %0d len %0d",
                       wanted.out_char, wanted.is_end, wanted.out_length,
                       m_tdata[7:0], m_tuser, m_tdata[18:8]);
          end
        end
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    bit long_done;
    int random_base;
    long_done = 1'b0;
    push_directed();
    random_base = chars_pushed;
    while (chars_pushed < random_base + RANDOM_ITEMS) begin
      if (!long_done && chars_pushed >= random_base + 300) begin
        push_long_uri();
        long_done = 1'b1;
      end else begin
        push_random_uri();
      end
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (raw_chars.size() != 0 || pending_decoded.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_decoded.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
